// File: hdl/zhpb_pkg.sv
// Shared types, constants and arithmetic helpers for the D2Q9 pressure boundary unit.
`default_nettype none

package zhpb_pkg;

   // Lattice geometry and number format.
   localparam int DIRECTIONS = 9;
   localparam int F_W        = 32;
   localparam int COORD_W    = 12;
   localparam int DIM_W      = 13;
   localparam int DIR_W      = 4;

   // Internal widths: density balance, tangential half difference,
   // divide-by-three operand and final accumulation.
   localparam int SUM_W = 36;
   localparam int T_W   = 34;
   localparam int DIV_W = 37;
   localparam int ACC_W = 38;

   // Default depth of the queue between the front and back ends.
   localparam int QUEUE_DEPTH = 2;

   localparam logic [DIM_W-1:0] LATTICE_DIM_RESET = DIM_W'(64);

   // Reciprocal of three for a 10-bit dividend, scaled by 2^11.
   localparam logic [19:0] DIV3_RECIP = 20'd683;

   localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'((64'sd1 <<< (F_W - 1)) - 64'sd1);
   localparam logic signed [ACC_W-1:0] SAT_MIN = ~SAT_MAX;

   // Direction codes, in the order of the populations.
   localparam logic [DIR_W-1:0] DIR_REST      = 4'd0;
   localparam logic [DIR_W-1:0] DIR_EAST      = 4'd1;
   localparam logic [DIR_W-1:0] DIR_NORTH     = 4'd2;
   localparam logic [DIR_W-1:0] DIR_WEST      = 4'd3;
   localparam logic [DIR_W-1:0] DIR_SOUTH     = 4'd4;
   localparam logic [DIR_W-1:0] DIR_NORTHEAST = 4'd5;
   localparam logic [DIR_W-1:0] DIR_NORTHWEST = 4'd6;
   localparam logic [DIR_W-1:0] DIR_SOUTHWEST = 4'd7;
   localparam logic [DIR_W-1:0] DIR_SOUTHEAST = 4'd8;

   typedef enum logic [0:0] {
      CSR_LATTICE_WIDTH  = 1'b0,
      CSR_LATTICE_HEIGHT = 1'b1
   } csr_index_type;

   // How the back end treats a queued item.
   typedef enum logic [1:0] {
      MODE_PASS   = 2'd0,
      MODE_EDGE   = 2'd1,
      MODE_CORNER = 2'd2
   } mode_type;

   typedef struct packed {
      logic [COORD_W-1:0] node_x;
      logic [COORD_W-1:0] node_y;
      logic [F_W-1:0]     target_density;
      logic [F_W-1:0]     dist_rest;
      logic [F_W-1:0]     dist_east;
      logic [F_W-1:0]     dist_north;
      logic [F_W-1:0]     dist_west;
      logic [F_W-1:0]     dist_south;
      logic [F_W-1:0]     dist_northeast;
      logic [F_W-1:0]     dist_northwest;
      logic [F_W-1:0]     dist_southwest;
      logic [F_W-1:0]     dist_southeast;
   } req_type;

   typedef struct packed {
      logic [F_W-1:0] new_rest;
      logic [F_W-1:0] new_east;
      logic [F_W-1:0] new_north;
      logic [F_W-1:0] new_west;
      logic [F_W-1:0] new_south;
      logic [F_W-1:0] new_northeast;
      logic [F_W-1:0] new_northwest;
      logic [F_W-1:0] new_southwest;
      logic [F_W-1:0] new_southeast;
      logic           not_on_boundary;
   } rsp_type;

   // A classified item: operands already picked for the edge or corner rule.
   typedef struct packed {
      mode_type                       mode;
      logic                           neg;
      logic [DIR_W-1:0]               ax_tgt;
      logic [DIR_W-1:0]               a_tgt;
      logic [DIR_W-1:0]               b_tgt;
      logic [F_W-1:0]                 rho;
      logic [F_W-1:0]                 ax_src;
      logic [F_W-1:0]                 a_src;
      logic [F_W-1:0]                 b_src;
      logic [F_W-1:0]                 tan_p;
      logic [F_W-1:0]                 tan_m;
      logic [DIRECTIONS-1:0][F_W-1:0] base;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // One radix-256 step of long division by three: returns quotient digit
   // and the new remainder.
   function automatic logic [9:0] div3_digit(input logic [1:0] rem, input logic [7:0] digit);
      logic [9:0]  v;
      logic [19:0] prod;
      logic [7:0]  q;
      logic [9:0]  q_times3;
      v        = {rem, digit};
      prod     = 20'(v) * DIV3_RECIP;
      q        = prod[18:11];
      q_times3 = 10'(q) * 10'd3;
      return {q, 2'(v - q_times3)};
   endfunction

   // Clamp an accumulated value to the signed 32-bit range.
   function automatic logic [F_W-1:0] sat_f(input logic signed [ACC_W-1:0] v);
      logic signed [ACC_W-1:0] c;
      c = v;
      if (v > SAT_MAX) begin
         c = SAT_MAX;
      end else if (v < SAT_MIN) begin
         c = SAT_MIN;
      end
      return c[F_W-1:0];
   endfunction

endpackage

`default_nettype wire

// File: hdl/zhpb_queue.sv
// Short register queue that decouples the classifying front end from the back end.
`default_nettype none

module zhpb_queue
   import zhpb_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  job_type          push_data,
   input  logic             pop,
   output job_type          pop_data,
   output queue_status_type status
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   job_type          entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign status.full  = (count_ff == CNT_W'(DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign pop_data     = entries_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage holds payload only.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// File: hdl/zhpb_front.sv
// Front end: lattice size registers, item acceptance and node classification.
`default_nettype none

module zhpb_front
   import zhpb_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  req_type          req_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  csr_index_type    csr_index,
   input  logic [DIM_W-1:0] csr_data,
   input  queue_status_type queue_status,
   output logic             push,
   output job_type          job
);

   logic [DIM_W-1:0]               width_ff, width_in;
   logic [DIM_W-1:0]               height_ff, height_in;
   logic [DIM_W-1:0]               x_next, y_next;
   logic                           at_left, at_right, at_low, at_high;
   logic [DIRECTIONS-1:0][F_W-1:0] f;

   assign csr_ready = 1'b1;
   assign busy      = queue_status.full;
   assign push      = start && !queue_status.full;

   // Configuration register writes.
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_LATTICE_WIDTH:  width_in  = csr_data;
            CSR_LATTICE_HEIGHT: height_in = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= LATTICE_DIM_RESET;
         height_ff <= LATTICE_DIM_RESET;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   // Edge detection; a far edge matches when position plus one equals the size,
   // so a size of zero never matches.
   assign x_next   = DIM_W'(req_data.node_x) + DIM_W'(1);
   assign y_next   = DIM_W'(req_data.node_y) + DIM_W'(1);
   assign at_left  = (req_data.node_x == '0);
   assign at_low   = (req_data.node_y == '0);
   assign at_right = (x_next == width_ff);
   assign at_high  = (y_next == height_ff);

   always_comb begin
      f[DIR_REST]      = req_data.dist_rest;
      f[DIR_EAST]      = req_data.dist_east;
      f[DIR_NORTH]     = req_data.dist_north;
      f[DIR_WEST]      = req_data.dist_west;
      f[DIR_SOUTH]     = req_data.dist_south;
      f[DIR_NORTHEAST] = req_data.dist_northeast;
      f[DIR_NORTHWEST] = req_data.dist_northwest;
      f[DIR_SOUTHWEST] = req_data.dist_southwest;
      f[DIR_SOUTHEAST] = req_data.dist_southeast;
   end

   // Classify the node and pick operands. Corners apply their bounce-back
   // copies here and leave the two buried diagonals to the back end.
   always_comb begin
      job.mode   = MODE_PASS;
      job.neg    = 1'b0;
      job.ax_tgt = DIR_REST;
      job.a_tgt  = DIR_REST;
      job.b_tgt  = DIR_REST;
      job.rho    = req_data.target_density;
      job.ax_src = '0;
      job.a_src  = '0;
      job.b_src  = '0;
      job.tan_p  = '0;
      job.tan_m  = '0;
      job.base   = f;
      if (at_left && at_low) begin
         job.mode                  = MODE_CORNER;
         job.base[DIR_EAST]        = f[DIR_WEST];
         job.base[DIR_NORTH]       = f[DIR_SOUTH];
         job.base[DIR_NORTHEAST]   = f[DIR_SOUTHWEST];
         job.ax_src                = f[DIR_WEST];
         job.a_src                 = f[DIR_SOUTH];
         job.b_src                 = f[DIR_SOUTHWEST];
         job.a_tgt                 = DIR_NORTHWEST;
         job.b_tgt                 = DIR_SOUTHEAST;
      end else if (at_left && at_high) begin
         job.mode                  = MODE_CORNER;
         job.base[DIR_SOUTH]       = f[DIR_NORTH];
         job.base[DIR_EAST]        = f[DIR_WEST];
         job.base[DIR_SOUTHEAST]   = f[DIR_NORTHWEST];
         job.ax_src                = f[DIR_NORTH];
         job.a_src                 = f[DIR_WEST];
         job.b_src                 = f[DIR_NORTHWEST];
         job.a_tgt                 = DIR_NORTHEAST;
         job.b_tgt                 = DIR_SOUTHWEST;
      end else if (at_right && at_low) begin
         job.mode                  = MODE_CORNER;
         job.base[DIR_WEST]        = f[DIR_EAST];
         job.base[DIR_NORTH]       = f[DIR_SOUTH];
         job.base[DIR_NORTHWEST]   = f[DIR_SOUTHEAST];
         job.ax_src                = f[DIR_EAST];
         job.a_src                 = f[DIR_SOUTH];
         job.b_src                 = f[DIR_SOUTHEAST];
         job.a_tgt                 = DIR_NORTHEAST;
         job.b_tgt                 = DIR_SOUTHWEST;
      end else if (at_right && at_high) begin
         job.mode                  = MODE_CORNER;
         job.base[DIR_WEST]        = f[DIR_EAST];
         job.base[DIR_SOUTH]       = f[DIR_NORTH];
         job.base[DIR_SOUTHWEST]   = f[DIR_NORTHEAST];
         job.ax_src                = f[DIR_EAST];
         job.a_src                 = f[DIR_NORTH];
         job.b_src                 = f[DIR_NORTHEAST];
         job.a_tgt                 = DIR_NORTHWEST;
         job.b_tgt                 = DIR_SOUTHEAST;
      end else if (at_left) begin
         job.mode   = MODE_EDGE;
         job.tan_p  = f[DIR_SOUTH];
         job.tan_m  = f[DIR_NORTH];
         job.ax_src = f[DIR_WEST];
         job.ax_tgt = DIR_EAST;
         job.a_src  = f[DIR_SOUTHWEST];
         job.a_tgt  = DIR_NORTHEAST;
         job.b_src  = f[DIR_NORTHWEST];
         job.b_tgt  = DIR_SOUTHEAST;
      end else if (at_right) begin
         job.mode   = MODE_EDGE;
         job.neg    = 1'b1;
         job.tan_p  = f[DIR_SOUTH];
         job.tan_m  = f[DIR_NORTH];
         job.ax_src = f[DIR_EAST];
         job.ax_tgt = DIR_WEST;
         job.a_src  = f[DIR_SOUTHEAST];
         job.a_tgt  = DIR_NORTHWEST;
         job.b_src  = f[DIR_NORTHEAST];
         job.b_tgt  = DIR_SOUTHWEST;
      end else if (at_low) begin
         job.mode   = MODE_EDGE;
         job.tan_p  = f[DIR_EAST];
         job.tan_m  = f[DIR_WEST];
         job.ax_src = f[DIR_SOUTH];
         job.ax_tgt = DIR_NORTH;
         job.a_src  = f[DIR_SOUTHEAST];
         job.a_tgt  = DIR_NORTHWEST;
         job.b_src  = f[DIR_SOUTHWEST];
         job.b_tgt  = DIR_NORTHEAST;
      end else if (at_high) begin
         job.mode   = MODE_EDGE;
         job.neg    = 1'b1;
         job.tan_p  = f[DIR_EAST];
         job.tan_m  = f[DIR_WEST];
         job.ax_src = f[DIR_NORTH];
         job.ax_tgt = DIR_SOUTH;
         job.a_src  = f[DIR_NORTHEAST];
         job.a_tgt  = DIR_SOUTHWEST;
         job.b_src  = f[DIR_NORTHWEST];
         job.b_tgt  = DIR_SOUTHEAST;
      end
   end

endmodule

`default_nettype wire

// File: hdl/zhpb_div3.sv
// Two-stage pipelined floor division of a signed value by three.
`default_nettype none

module zhpb_div3
   import zhpb_pkg::*;
(
   input  logic                    clock,
   input  logic signed [DIV_W-1:0] dividend,
   output logic signed [DIV_W-1:0] quotient
);

   // The dividend is biased by three times 2^(DIV_W-1) to make it positive,
   // then divided one byte per step.
   localparam int DIGITS = (DIV_W + 1 + 7) / 8;
   localparam int U_W    = DIGITS * 8;
   localparam int SPLIT  = DIGITS / 2;
   localparam int HI_W   = (DIGITS - SPLIT) * 8;
   localparam int LO_W   = SPLIT * 8;
   localparam logic [U_W-1:0] BIAS_IN  = U_W'(3) << (DIV_W - 1);
   localparam logic [U_W-1:0] BIAS_OUT = U_W'(1) << (DIV_W - 1);

   logic [U_W-1:0]   biased;
   logic [HI_W-1:0]  q_hi_ff, q_hi_in;
   logic [1:0]       rem_ff, rem_in;
   logic [LO_W-1:0]  u_lo_ff;
   logic [LO_W-1:0]  q_lo;
   logic [U_W-1:0]   q_full;
   logic signed [DIV_W-1:0] quotient_ff, quotient_in;

   assign biased = {{(U_W - DIV_W){dividend[DIV_W-1]}}, dividend} + BIAS_IN;

   // Upper digits.
   always_comb begin
      logic [1:0] rem;
      logic [9:0] step;
      rem     = 2'd0;
      q_hi_in = '0;
      for (int k = DIGITS - 1; k >= SPLIT; k--) begin
         step                          = div3_digit(rem, biased[k*8 +: 8]);
         q_hi_in[(k - SPLIT)*8 +: 8]   = step[9:2];
         rem                           = step[1:0];
      end
      rem_in = rem;
   end

   always_ff @(posedge clock) begin
      q_hi_ff <= q_hi_in;
      rem_ff  <= rem_in;
      u_lo_ff <= biased[LO_W-1:0];
   end

   // Lower digits and removal of the bias.
   always_comb begin
      logic [1:0] rem;
      logic [9:0] step;
      rem  = rem_ff;
      q_lo = '0;
      for (int k = SPLIT - 1; k >= 0; k--) begin
         step             = div3_digit(rem, u_lo_ff[k*8 +: 8]);
         q_lo[k*8 +: 8]   = step[9:2];
         rem              = step[1:0];
      end
      q_full      = {q_hi_ff, q_lo} - BIAS_OUT;
      quotient_in = q_full[DIV_W-1:0];
   end

   always_ff @(posedge clock) begin
      quotient_ff <= quotient_in;
   end

   assign quotient = quotient_ff;

endmodule

`default_nettype wire

// File: hdl/zhpb_back.sv
// Back end: density balance, rounded scaling, population rebuild and result register.
`default_nettype none

module zhpb_back
   import zhpb_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    job_valid,
   input  job_type job,
   output logic    pop,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   typedef struct packed {
      mode_type                       mode;
      logic                           neg;
      logic [DIR_W-1:0]               ax_tgt;
      logic [DIR_W-1:0]               a_tgt;
      logic [DIR_W-1:0]               b_tgt;
      logic [F_W-1:0]                 ax_src;
      logic [F_W-1:0]                 a_src;
      logic [F_W-1:0]                 b_src;
      logic signed [T_W-1:0]          t;
      logic signed [SUM_W-1:0]        half;
      logic [DIRECTIONS-1:0][F_W-1:0] base;
   } stage_type;

   stage_type               s1_in, s1_ff, s2_ff, s3_ff;
   logic                    s1_valid_ff, s2_valid_ff, s3_valid_ff;
   logic signed [DIV_W-1:0] n23_in, n23_ff, n16_in, n16_ff;
   logic signed [DIV_W-1:0] q23, q16;
   logic signed [SUM_W-1:0] known_sum, balance, d, r;
   rsp_type                 rsp_in, rsp_ff;
   logic                    rsp_valid_ff;

   // The back end never stalls, so it takes the queue head whenever there is one.
   assign pop = job_valid;

   // Stage 1: density balance, tangential half difference and corner half.
   always_comb begin
      known_sum = SUM_W'($signed(job.ax_src)) + SUM_W'($signed(job.a_src))
                + SUM_W'($signed(job.b_src));
      balance   = SUM_W'($signed(job.tan_p)) + SUM_W'($signed(job.tan_m)) + (known_sum <<< 1);
      d         = SUM_W'($signed(job.rho)) - balance;
      r         = job.neg ? -d : d;
      // Rounded 2r/3 is floor((2r+1)/3); rounded r/6 is floor(floor((r+3)/2)/3).
      n23_in    = (DIV_W'(r) <<< 1) + DIV_W'(1);
      n16_in    = (DIV_W'(r) + DIV_W'(3)) >>> 1;

      s1_in.mode   = job.mode;
      s1_in.neg    = job.neg;
      s1_in.ax_tgt = job.ax_tgt;
      s1_in.a_tgt  = job.a_tgt;
      s1_in.b_tgt  = job.b_tgt;
      s1_in.ax_src = job.ax_src;
      s1_in.a_src  = job.a_src;
      s1_in.b_src  = job.b_src;
      s1_in.t      = (T_W'($signed(job.tan_p)) - T_W'($signed(job.tan_m)) + T_W'(1)) >>> 1;
      s1_in.half   = (d + SUM_W'(1)) >>> 1;
      s1_in.base   = job.base;
   end

   always_ff @(posedge clock) begin
      s1_ff  <= s1_in;
      n23_ff <= n23_in;
      n16_ff <= n16_in;
      s2_ff  <= s1_ff;
      s3_ff  <= s2_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= job_valid;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         rsp_valid_ff <= s3_valid_ff;
      end
   end

   // Stages 2 and 3: the two divisions by three.
   zhpb_div3 u_div23 (
      .clock    (clock),
      .dividend (n23_ff),
      .quotient (q23)
   );

   zhpb_div3 u_div16 (
      .clock    (clock),
      .dividend (n16_ff),
      .quotient (q16)
   );

   // Stage 4: rebuild the unknown populations, saturate and place them.
   always_comb begin
      logic signed [ACC_W-1:0]        d23, d16, ax_sum, a_sum, b_sum;
      logic [F_W-1:0]                 ax_new, a_new, b_new, half_new;
      logic [DIRECTIONS-1:0][F_W-1:0] out;
      d23      = s3_ff.neg ? -ACC_W'(q23) : ACC_W'(q23);
      d16      = s3_ff.neg ? -ACC_W'(q16) : ACC_W'(q16);
      ax_sum   = ACC_W'($signed(s3_ff.ax_src)) + d23;
      a_sum    = ACC_W'($signed(s3_ff.a_src)) + ACC_W'(s3_ff.t) + d16;
      b_sum    = ACC_W'($signed(s3_ff.b_src)) - ACC_W'(s3_ff.t) + d16;
      ax_new   = sat_f(ax_sum);
      a_new    = sat_f(a_sum);
      b_new    = sat_f(b_sum);
      half_new = sat_f(ACC_W'(s3_ff.half));
      out      = s3_ff.base;
      for (int i = 0; i < DIRECTIONS; i++) begin
         case (s3_ff.mode)
            MODE_EDGE: begin
               if (DIR_W'(i) == s3_ff.ax_tgt) begin
                  out[i] = ax_new;
               end else if (DIR_W'(i) == s3_ff.a_tgt) begin
                  out[i] = a_new;
               end else if (DIR_W'(i) == s3_ff.b_tgt) begin
                  out[i] = b_new;
               end
            end
            MODE_CORNER: begin
               if (DIR_W'(i) == s3_ff.a_tgt || DIR_W'(i) == s3_ff.b_tgt) begin
                  out[i] = half_new;
               end
            end
            default: ;
         endcase
      end
      rsp_in.new_rest        = out[DIR_REST];
      rsp_in.new_east        = out[DIR_EAST];
      rsp_in.new_north       = out[DIR_NORTH];
      rsp_in.new_west        = out[DIR_WEST];
      rsp_in.new_south       = out[DIR_SOUTH];
      rsp_in.new_northeast   = out[DIR_NORTHEAST];
      rsp_in.new_northwest   = out[DIR_NORTHWEST];
      rsp_in.new_southwest   = out[DIR_SOUTHWEST];
      rsp_in.new_southeast   = out[DIR_SOUTHEAST];
      rsp_in.not_on_boundary = (s3_ff.mode == MODE_PASS);
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

// File: hdl/zou_he_pressure_boundary_d2q9_unit.sv
// Top level of the D2Q9 Zou-He pressure boundary node unit.
//
//   channel   | handshake               | payload
//   ----------+-------------------------+-----------------------------------
//   request   | start / busy            | req_data  (node, density, 9 pops)
//   response  | rsp_valid (strobe)      | rsp_data  (9 pops, interior flag)
//   csr write | csr_valid / csr_ready   | csr_index, csr_data (13 bit)
//
// One item is accepted per cycle while busy is low. Its result passes in order
// through the front-end queue entry, the balance stage, the two digit stages of
// the divide-by-three units and the result register, where the result strobe
// rises. Reset is synchronous, clears the control state and sets both lattice
// sizes to 64. The receiver cannot stall, so the back end drains the queue
// every cycle and busy rises only if the queue fills.
`default_nettype none

module zou_he_pressure_boundary_d2q9_unit
   import zhpb_pkg::*;
#(
   parameter int QUEUE_ENTRIES = QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  req_type          req_data,
   output logic             rsp_valid,
   output rsp_type          rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  csr_index_type    csr_index,
   input  logic [DIM_W-1:0] csr_data
);

   queue_status_type queue_status;
   logic             push, pop;
   job_type          push_job, pop_job;

   // Front end: configuration and classification.
   zhpb_front u_front (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_data     (req_data),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .queue_status (queue_status),
      .push         (push),
      .job          (push_job)
   );

   // Queue between the two halves.
   zhpb_queue #(
      .DEPTH (QUEUE_ENTRIES)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_job),
      .pop       (pop),
      .pop_data  (pop_job),
      .status    (queue_status)
   );

   // Back end: arithmetic and result register.
   zhpb_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (!queue_status.empty),
      .job       (pop_job),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

// File: dv/boundary_checker.sv
// Watches the node, result and register channels, predicts each boundary update and compares.
`timescale 1ns / 1ps

module boundary_checker
   import zhpb_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic             busy,
   input  req_type          req_data,
   input  logic             rsp_valid,
   input  rsp_type          rsp_data,
   input  logic             csr_valid,
   input  logic             csr_ready,
   input  csr_index_type    csr_index,
   input  logic [DIM_W-1:0] csr_data,
   output int               fail_count,
   output int               outstanding
);

   // Directions whose populations are known at each corner node.
   localparam logic [DIRECTIONS-1:0] KNOWN_LOW_LEFT =
      (DIRECTIONS'(1) << DIR_WEST) | (DIRECTIONS'(1) << DIR_SOUTH) |
      (DIRECTIONS'(1) << DIR_SOUTHWEST);
   localparam logic [DIRECTIONS-1:0] KNOWN_HIGH_LEFT =
      (DIRECTIONS'(1) << DIR_NORTH) | (DIRECTIONS'(1) << DIR_WEST) |
      (DIRECTIONS'(1) << DIR_NORTHWEST);
   localparam logic [DIRECTIONS-1:0] KNOWN_LOW_RIGHT =
      (DIRECTIONS'(1) << DIR_EAST) | (DIRECTIONS'(1) << DIR_SOUTH) |
      (DIRECTIONS'(1) << DIR_SOUTHEAST);
   localparam logic [DIRECTIONS-1:0] KNOWN_HIGH_RIGHT =
      (DIRECTIONS'(1) << DIR_EAST) | (DIRECTIONS'(1) << DIR_NORTH) |
      (DIRECTIONS'(1) << DIR_NORTHEAST);

   localparam longint POP_MAX = 64'sd2147483647;
   localparam longint POP_MIN = -64'sd2147483648;

   string dir_label [DIRECTIONS] = '{"rest", "east", "north", "west", "south",
                                     "northeast", "northwest", "southwest", "southeast"};

   logic [DIM_W-1:0] width_setting;
   logic [DIM_W-1:0] height_setting;
   rsp_type          pending_nodes [$];

   // Direction pointing the opposite way.
   function automatic int reverse_of(input int d);
      case (d)
         DIR_EAST:      return DIR_WEST;
         DIR_NORTH:     return DIR_SOUTH;
         DIR_WEST:      return DIR_EAST;
         DIR_SOUTH:     return DIR_NORTH;
         DIR_NORTHEAST: return DIR_SOUTHWEST;
         DIR_NORTHWEST: return DIR_SOUTHEAST;
         DIR_SOUTHWEST: return DIR_NORTHEAST;
         DIR_SOUTHEAST: return DIR_NORTHWEST;
         default:       return DIR_REST;
      endcase
   endfunction

   // v * k / d rounded to the nearest step, ties toward plus infinity.
   function automatic longint round_scaled(input longint v, input longint k, input longint d);
      longint num;
      longint den;
      longint q;
      num = 2 * v * k + d;
      den = 2 * d;
      q = num / den;
      if ((num % den) != 0 && num < 0) begin
         q = q - 1;
      end
      return q;
   endfunction

   // Expected result of one boundary node under the given lattice size.
   function automatic rsp_type boundary_update(input req_type node,
                                               input logic [DIM_W-1:0] width,
                                               input logic [DIM_W-1:0] height);
      logic [DIRECTIONS-1:0][F_W-1:0] pops_in;
      logic [DIRECTIONS-1:0][F_W-1:0] pops_out;
      logic [COORD_W-1:0]             x_bits;
      logic [COORD_W-1:0]             y_bits;
      logic [F_W-1:0]                 rho_bits;
      longint                         f [DIRECTIONS];
      longint                         x, y, xe, ye, rho, r, t, sum, half;
      logic [DIRECTIONS-1:0]          known;
      logic                           interior;
      {x_bits, y_bits, rho_bits, pops_in} = node;
      x   = x_bits;
      y   = y_bits;
      xe  = width;
      xe  = xe - 1;
      ye  = height;
      ye  = ye - 1;
      rho = $signed(rho_bits);
      for (int d = 0; d < DIRECTIONS; d++) begin
         f[d] = $signed(pops_in[DIRECTIONS-1-d]);
      end
      known    = '0;
      interior = 1'b0;

      // Corners take priority over edges; edges go left, right, low, high.
      if (x == 0 && y == 0) begin
         known = KNOWN_LOW_LEFT;
      end else if (x == 0 && y == ye) begin
         known = KNOWN_HIGH_LEFT;
      end else if (x == xe && y == 0) begin
         known = KNOWN_LOW_RIGHT;
      end else if (x == xe && y == ye) begin
         known = KNOWN_HIGH_RIGHT;
      end else if (x == 0) begin
         r = rho - (f[DIR_NORTH] + f[DIR_SOUTH] +
                    2 * (f[DIR_WEST] + f[DIR_NORTHWEST] + f[DIR_SOUTHWEST]));
         t = round_scaled(f[DIR_SOUTH] - f[DIR_NORTH], 1, 2);
         f[DIR_EAST]      = f[DIR_WEST] + round_scaled(r, 2, 3);
         f[DIR_NORTHEAST] = f[DIR_SOUTHWEST] + t + round_scaled(r, 1, 6);
         f[DIR_SOUTHEAST] = f[DIR_NORTHWEST] - t + round_scaled(r, 1, 6);
      end else if (x == xe) begin
         r = (f[DIR_NORTH] + f[DIR_SOUTH] +
              2 * (f[DIR_EAST] + f[DIR_NORTHEAST] + f[DIR_SOUTHEAST])) - rho;
         t = round_scaled(f[DIR_SOUTH] - f[DIR_NORTH], 1, 2);
         f[DIR_WEST]      = f[DIR_EAST] - round_scaled(r, 2, 3);
         f[DIR_SOUTHWEST] = f[DIR_NORTHEAST] - t - round_scaled(r, 1, 6);
         f[DIR_NORTHWEST] = f[DIR_SOUTHEAST] + t - round_scaled(r, 1, 6);
      end else if (y == 0) begin
         r = rho - (f[DIR_EAST] + f[DIR_WEST] +
                    2 * (f[DIR_SOUTHWEST] + f[DIR_SOUTH] + f[DIR_SOUTHEAST]));
         t = round_scaled(f[DIR_EAST] - f[DIR_WEST], 1, 2);
         f[DIR_NORTH]     = f[DIR_SOUTH] + round_scaled(r, 2, 3);
         f[DIR_NORTHEAST] = f[DIR_SOUTHWEST] - t + round_scaled(r, 1, 6);
         f[DIR_NORTHWEST] = f[DIR_SOUTHEAST] + t + round_scaled(r, 1, 6);
      end else if (y == ye) begin
         r = (f[DIR_EAST] + f[DIR_WEST] +
              2 * (f[DIR_NORTH] + f[DIR_NORTHEAST] + f[DIR_NORTHWEST])) - rho;
         t = round_scaled(f[DIR_EAST] - f[DIR_WEST], 1, 2);
         f[DIR_SOUTH]     = f[DIR_NORTH] - round_scaled(r, 2, 3);
         f[DIR_SOUTHWEST] = f[DIR_NORTHEAST] + t - round_scaled(r, 1, 6);
         f[DIR_SOUTHEAST] = f[DIR_NORTHWEST] - t - round_scaled(r, 1, 6);
      end else begin
         interior = 1'b1;
      end

      // At a corner, known directions bounce back and the buried diagonals
      // share what is left of the density.
      if (known != '0) begin
         sum = 0;
         for (int d = DIR_EAST; d < DIRECTIONS; d++) begin
            if (known[d]) begin
               f[reverse_of(d)] = f[d];
               sum = sum + 2 * f[d];
            end
         end
         half = round_scaled(rho - sum, 1, 2);
         for (int d = DIR_EAST; d < DIRECTIONS; d++) begin
            if (!known[d] && !known[reverse_of(d)]) begin
               f[d] = half;
            end
         end
      end

      // Saturate every population to the signed 32-bit range.
      for (int d = 0; d < DIRECTIONS; d++) begin
         if (f[d] > POP_MAX) begin
            f[d] = POP_MAX;
         end else if (f[d] < POP_MIN) begin
            f[d] = POP_MIN;
         end
         pops_out[DIRECTIONS-1-d] = F_W'(f[d]);
      end
      return rsp_type'({pops_out, interior});
   endfunction

   task automatic report_mismatch(input string msg);
      $display("%0t ns: mismatch: %s", $time, msg);
      fail_count = fail_count + 1;
   endtask

   // Field by field comparison of one result with its expectation.
   task automatic compare_node(input rsp_type got, input rsp_type want);
      logic [DIRECTIONS-1:0][F_W-1:0] got_pops;
      logic [DIRECTIONS-1:0][F_W-1:0] want_pops;
      logic                           got_flag;
      logic                           want_flag;
      {got_pops, got_flag}   = got;
      {want_pops, want_flag} = want;
      for (int d = 0; d < DIRECTIONS; d++) begin
         if (got_pops[DIRECTIONS-1-d] !== want_pops[DIRECTIONS-1-d]) begin
            report_mismatch($sformatf("new_%s got %h expected %h", dir_label[d],
                                      got_pops[DIRECTIONS-1-d], want_pops[DIRECTIONS-1-d]));
         end
      end
      if (got_flag !== want_flag) begin
         report_mismatch($sformatf("not_on_boundary got %b expected %b", got_flag, want_flag));
      end
   endtask

   // Append one expectation behind the ones already waiting.
   task automatic enqueue_expected(input rsp_type want);
      pending_nodes.insert(pending_nodes.size(), want);
   endtask

   // Track the lattice size, queue an expectation per accepted item and
   // check each result strobe against the oldest one.
   always @(posedge clock) begin
      if (reset) begin
         width_setting  = LATTICE_DIM_RESET;
         height_setting = LATTICE_DIM_RESET;
         fail_count     = 0;
         pending_nodes.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_LATTICE_WIDTH:  width_setting = csr_data;
               CSR_LATTICE_HEIGHT: height_setting = csr_data;
               default: ;
            endcase
         end
         if (rsp_valid) begin
            if (pending_nodes.size() == 0) begin
               report_mismatch("result with no item outstanding");
            end else begin
               compare_node(rsp_data, pending_nodes.pop_front());
            end
         end
         if (start && !busy) begin
            enqueue_expected(boundary_update(req_data, width_setting, height_setting));
         end
      end
      outstanding <= pending_nodes.size();
   end

endmodule

// File: dv/tb_top.sv
// Stimulus, clock, reset and verdict for the D2Q9 pressure boundary unit.
`timescale 1ns / 1ps

module tb_top
   import zhpb_pkg::*;
();

   localparam int STALL_LIMIT   = 2000;
   localparam int SETTLE_CYCLES = 10;
   localparam int PHASE_ITEMS   = 130;
   localparam int PHASES        = 8;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             start = 1'b0;
   logic             busy;
   req_type          req_data = '0;
   logic             rsp_valid;
   rsp_type          rsp_data;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   csr_index_type    csr_index = CSR_LATTICE_WIDTH;
   logic [DIM_W-1:0] csr_data = '0;

   int               fail_count;
   int               outstanding;
   int               stall_cycles = 0;
   int               cur_width = 64;
   int               cur_height = 64;

   always #4 clock = ~clock;

   zou_he_pressure_boundary_d2q9_unit DUT (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   boundary_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   // Watchdog: ends the run when no channel has moved for too long.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= STALL_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // Population mix: extremes, small values that land on rounding ties,
   // typical densities and full-range noise.
   function automatic logic [F_W-1:0] random_population();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 8) begin
         return 32'h7FFF_FFFF;
      end else if (pick < 16) begin
         return 32'h8000_0000;
      end else if (pick < 36) begin
         return F_W'($urandom_range(128)) - 32'd64;
      end else if (pick < 66) begin
         return F_W'($urandom_range(32'h2000_0000));
      end
      return F_W'($urandom());
   endfunction

   // Coordinates biased toward the near and far edges of one axis.
   function automatic logic [COORD_W-1:0] random_coord(input int dim);
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 25) begin
         return '0;
      end else if (pick < 50) begin
         return COORD_W'(dim - 1);
      end else if (pick < 80 && dim > 2) begin
         return COORD_W'($urandom_range(dim - 2, 1));
      end
      return COORD_W'($urandom_range(4095));
   endfunction

   // Offer one item, wait for it to be taken, then maybe leave a gap.
   task automatic send_node(input req_type node, input int idle_pct);
      req_data <= node;
      start    <= 1'b1;
      @(posedge clock);
      while (busy) begin
         @(posedge clock);
      end
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         do begin
            @(posedge clock);
         end while ($urandom_range(99) < idle_pct);
      end
   endtask

   // Hold off until every result is back and the pipeline has emptied.
   task automatic drain_results();
      start <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write both lattice sizes back to back on the register channel.
   task automatic configure_lattice(input int width, input int height);
      csr_index <= CSR_LATTICE_WIDTH;
      csr_data  <= DIM_W'(width);
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) begin
         @(posedge clock);
      end
      csr_index <= CSR_LATTICE_HEIGHT;
      csr_data  <= DIM_W'(height);
      @(posedge clock);
      while (!csr_ready) begin
         @(posedge clock);
      end
      csr_valid  <= 1'b0;
      cur_width  = width;
      cur_height = height;
   endtask

   // Corners, each edge, the interior and nodes beyond the lattice under the
   // reset size, once with saturating extremes and once with small values.
   task automatic run_directed();
      int      xs [12] = '{0, 0, 63, 63, 0, 63, 20, 20, 30, 4095, 4095, 0};
      int      ys [12] = '{0, 63, 0, 63, 40, 40, 0, 63, 30, 4095, 0, 4095};
      req_type node;
      for (int i = 0; i < 12; i++) begin
         node.node_x = COORD_W'(xs[i]);
         node.node_y = COORD_W'(ys[i]);
         node.target_density = (i % 2 == 0) ? 32'h8000_0000 : 32'h7FFF_FFFF;
         node.dist_rest      = (i % 2 == 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
         node.dist_east      = node.dist_rest;
         node.dist_north     = node.dist_rest;
         node.dist_west      = node.dist_rest;
         node.dist_south     = node.dist_rest;
         node.dist_northeast = node.dist_rest;
         node.dist_northwest = node.dist_rest;
         node.dist_southwest = node.dist_rest;
         node.dist_southeast = node.dist_rest;
         send_node(node, 0);
         node.target_density = F_W'($urandom_range(16)) - 32'd8;
         node.dist_rest      = F_W'($urandom_range(16)) - 32'd8;
         node.dist_east      = F_W'($urandom_range(16)) - 32'd8;
         node.dist_north     = F_W'($urandom_range(16)) - 32'd8;
         node.dist_west      = F_W'($urandom_range(16)) - 32'd8;
         node.dist_south     = F_W'($urandom_range(16)) - 32'd8;
         node.dist_northeast = F_W'($urandom_range(16)) - 32'd8;
         node.dist_northwest = F_W'($urandom_range(16)) - 32'd8;
         node.dist_southwest = F_W'($urandom_range(16)) - 32'd8;
         node.dist_southeast = F_W'($urandom_range(16)) - 32'd8;
         send_node(node, 0);
      end
   endtask

   // One phase of random nodes under the current lattice size.
   task automatic run_random(input int idle_pct);
      req_type node;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
         node.node_x         = random_coord(cur_width);
         node.node_y         = random_coord(cur_height);
         node.target_density = random_population();
         node.dist_rest      = random_population();
         node.dist_east      = random_population();
         node.dist_north     = random_population();
         node.dist_west      = random_population();
         node.dist_south     = random_population();
         node.dist_northeast = random_population();
         node.dist_northwest = random_population();
         node.dist_southwest = random_population();
         node.dist_southeast = random_population();
         send_node(node, idle_pct);
      end
   endtask

   // Main sequence: reset, directed nodes, then phases of lattice sizes and
   // sender idling, including the smallest and largest lattices.
   initial begin
      int widths [PHASES]  = '{2, 4096, 2, 4096, 0, 0, 0, 0};
      int heights [PHASES] = '{2, 4096, 4096, 2, 0, 0, 0, 0};
      int idle_pct [4]     = '{0, 86, 0, 33};
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      run_directed();
      for (int p = 0; p < PHASES; p++) begin
         if (p >= 4) begin
            widths[p]  = (p % 2 == 0) ? $urandom_range(12, 3) : $urandom_range(4096, 2);
            heights[p] = (p % 2 == 0) ? $urandom_range(4096, 2) : $urandom_range(12, 3);
         end
         drain_results();
         configure_lattice(widths[p], heights[p]);
         run_random(idle_pct[p % 4]);
      end
      drain_results();
      if (fail_count == 0 && outstanding == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

// File: sim.f
hdl/zhpb_pkg.sv
hdl/zhpb_queue.sv
hdl/zhpb_front.sv
hdl/zhpb_div3.sv
hdl/zhpb_back.sv
hdl/zou_he_pressure_boundary_d2q9_unit.sv
dv/boundary_checker.sv
dv/tb_top.sv
